// ===== hw/rtl/cpc_pkg.sv =====
// cpc_pkg: shared types, widths, constants and the arctangent table of the converter
package cpc_pkg;

    localparam int DATA_W   = 24;
    localparam int GUARD    = 8;
    localparam int KINV_W   = 30;
    localparam int XW       = DATA_W + GUARD + 3;
    localparam int ZW       = DATA_W + 2;
    localparam int SQ_W     = 2 * DATA_W;
    localparam int REM_W    = DATA_W + 2;
    localparam int R_W      = XW - GUARD + 1;
    localparam int KPROD_W  = DATA_W + KINV_W;

    localparam logic [KINV_W-1:0] KINV_Q30 = 30'd652032874;

    localparam logic signed [DATA_W-1:0] PI_D      = DATA_W'(longint'(1) <<< (DATA_W - 2));
    localparam logic signed [DATA_W-1:0] HALF_PI_D = DATA_W'(longint'(1) <<< (DATA_W - 3));
    localparam logic signed [DATA_W-1:0] SAT_HI    = DATA_W'((longint'(1) <<< (DATA_W - 1)) - 1);
    localparam logic signed [DATA_W-1:0] SAT_LO    = DATA_W'(-(longint'(1) <<< (DATA_W - 1)));

    // atan(2^-i) with pi = 2^22
    localparam longint ATAN_TAB [32] = '{
        1048576, 619011, 327068, 166025, 83335, 41708, 20859, 10430,
        5215, 2608, 1304, 652, 326, 163, 81, 41,
        20, 10, 5, 3, 1, 1, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] in_real;
        logic signed [DATA_W-1:0] in_imag;
        logic        [DATA_W-1:0] in_magnitude;
        logic signed [DATA_W-1:0] in_phase;
    } cpc_req_t;

    typedef struct packed {
        logic        [DATA_W-1:0] out_magnitude;
        logic signed [DATA_W-1:0] out_phase;
        logic signed [DATA_W-1:0] out_real;
        logic signed [DATA_W-1:0] out_imag;
        logic                     saturated;
    } cpc_rsp_t;

    // per-transaction flags that ride alongside the datapath
    typedef struct packed {
        logic to_rect;
        logic flip;
        logic re_neg;
        logic re_zero;
        logic im_pos;
    } cpc_side_t;

    function automatic longint cpc_angle(input int idx);
        longint base;
        base = ATAN_TAB[idx & 31];
        if (DATA_W >= 24)
        begin
            return base <<< (DATA_W - 24);
        end
        else
        begin
            return (base + (longint'(1) <<< (23 - DATA_W))) >>> (24 - DATA_W);
        end
    endfunction

endpackage

// ===== hw/rtl/cpc_prep.sv =====
// cpc_prep: two input stages with the squares, inverse-gain product, folding and start values
module cpc_prep
    import cpc_pkg::*;
(
    input  logic                    clk,
    input  logic                    en_a,
    input  logic                    en_b,
    input  cpc_req_t                req,
    output cpc_side_t               side,
    output logic signed [XW-1:0]    x,
    output logic signed [XW-1:0]    y,
    output logic signed [ZW-1:0]    z,
    output logic        [SQ_W-1:0]  sq
);

    cpc_side_t                   side_a_next, side_a_reg;
    logic signed [XW-1:0]        vx_a_next, vx_a_reg;
    logic signed [XW-1:0]        vy_a_next, vy_a_reg;
    logic signed [ZW-1:0]        z_a_next, z_a_reg;
    logic signed [SQ_W-1:0]      sq_re_a_next, sq_im_a_next;
    logic        [SQ_W-1:0]      sq_re_a_reg, sq_im_a_reg;
    logic        [KPROD_W-1:0]   kprod_a_next, kprod_a_reg;

    cpc_side_t                   side_b_reg;
    logic signed [XW-1:0]        x_b_next, x_b_reg;
    logic signed [XW-1:0]        y_b_next, y_b_reg;
    logic signed [ZW-1:0]        z_b_next, z_b_reg;
    logic        [SQ_W-1:0]      sq_b_next, sq_b_reg;

    logic signed [XW-1:0]        re_w, im_w;
    logic signed [DATA_W-2:0]    ph_fold;
    logic signed [DATA_W-1:0]    ph_w;

    always_comb
    begin
        re_w = XW'(req.in_real);
        im_w = XW'(req.in_imag);

        side_a_next.to_rect = req.req_type;
        side_a_next.re_neg  = req.in_real[DATA_W-1];
        side_a_next.re_zero = (req.in_real == '0);
        side_a_next.im_pos  = !req.in_imag[DATA_W-1] && (req.in_imag != '0);

        // left half plane is mirrored into the right before vectoring
        if (req.in_real[DATA_W-1])
        begin
            vx_a_next = (-re_w) <<< GUARD;
            vy_a_next = (-im_w) <<< GUARD;
        end
        else
        begin
            vx_a_next = re_w <<< GUARD;
            vy_a_next = im_w <<< GUARD;
        end

        sq_re_a_next = req.in_real * req.in_real;
        sq_im_a_next = req.in_imag * req.in_imag;
        kprod_a_next = req.in_magnitude * KINV_Q30;

        // phase wraps modulo 2 pi, then folds into the right half plane
        ph_fold = $signed(req.in_phase[DATA_W-2:0]);
        ph_w    = DATA_W'(ph_fold);
        if (ph_w > HALF_PI_D)
        begin
            z_a_next         = ZW'(ph_w - PI_D);
            side_a_next.flip = 1'b1;
        end
        else if (ph_w < -HALF_PI_D)
        begin
            z_a_next         = ZW'(ph_w + PI_D);
            side_a_next.flip = 1'b1;
        end
        else
        begin
            z_a_next         = ZW'(ph_w);
            side_a_next.flip = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            side_a_reg  <= side_a_next;
            vx_a_reg    <= vx_a_next;
            vy_a_reg    <= vy_a_next;
            z_a_reg     <= z_a_next;
            sq_re_a_reg <= $unsigned(sq_re_a_next);
            sq_im_a_reg <= $unsigned(sq_im_a_next);
            kprod_a_reg <= kprod_a_next;
        end
    end

    always_comb
    begin
        sq_b_next = sq_re_a_reg + sq_im_a_reg;
        if (side_a_reg.to_rect)
        begin
            x_b_next = XW'(kprod_a_reg >> (KINV_W - GUARD));
            y_b_next = '0;
            z_b_next = z_a_reg;
        end
        else
        begin
            x_b_next = vx_a_reg;
            y_b_next = vy_a_reg;
            z_b_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            side_b_reg <= side_a_reg;
            x_b_reg    <= x_b_next;
            y_b_reg    <= y_b_next;
            z_b_reg    <= z_b_next;
            sq_b_reg   <= sq_b_next;
        end
    end

    assign side = side_b_reg;
    assign x    = x_b_reg;
    assign y    = y_b_reg;
    assign z    = z_b_reg;
    assign sq   = sq_b_reg;

endmodule

// ===== hw/rtl/cpc_cordic_stage.sv =====
// cpc_cordic_stage: one registered cordic micro-rotation, vectoring or rotation per transaction
module cpc_cordic_stage
    import cpc_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int STAGES = 24
)
(
    input  logic                  clk,
    input  logic                  en,
    input  cpc_side_t             side_in,
    input  logic signed [XW-1:0]  x_in,
    input  logic signed [XW-1:0]  y_in,
    input  logic signed [ZW-1:0]  z_in,
    output cpc_side_t             side,
    output logic signed [XW-1:0]  x,
    output logic signed [XW-1:0]  y,
    output logic signed [ZW-1:0]  z
);

    localparam logic signed [ZW-1:0] ANG = ZW'(cpc_angle(IDX));

    cpc_side_t             side_reg;
    logic signed [XW-1:0]  x_next, x_reg;
    logic signed [XW-1:0]  y_next, y_reg;
    logic signed [ZW-1:0]  z_next, z_reg;
    logic signed [XW-1:0]  xs, ys;
    logic                  pos;

    always_comb
    begin
        xs  = x_in >>> IDX;
        ys  = y_in >>> IDX;
        // rotation steers on the residual angle, vectoring on the sign of y
        pos = side_in.to_rect ? !z_in[ZW-1] : y_in[XW-1];
        if (IDX >= STAGES)
        begin
            x_next = x_in;
            y_next = y_in;
            z_next = z_in;
        end
        else if (pos)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ANG;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
        end
    end

    assign side = side_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;

endmodule

// ===== hw/rtl/cpc_sqrt_stage.sv =====
// cpc_sqrt_stage: one registered digit of the restoring integer square root
module cpc_sqrt_stage
    import cpc_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [SQ_W-1:0]     s_in,
    input  logic [REM_W-1:0]    rem_in,
    input  logic [DATA_W-1:0]   root_in,
    output logic [SQ_W-1:0]     s,
    output logic [REM_W-1:0]    rem,
    output logic [DATA_W-1:0]   root
);

    logic [SQ_W-1:0]    s_next, s_reg;
    logic [REM_W-1:0]   rem_next, rem_reg;
    logic [DATA_W-1:0]  root_next, root_reg;
    logic [REM_W+1:0]   rem_sh, trial, diff;

    always_comb
    begin
        rem_sh = {rem_in, s_in[SQ_W-1 -: 2]};
        trial  = {2'b00, root_in, 2'b01};
        diff   = rem_sh - trial;
        if (IDX >= DATA_W)
        begin
            s_next    = s_in;
            rem_next  = rem_in;
            root_next = root_in;
        end
        else if (rem_sh >= trial)
        begin
            s_next    = s_in << 2;
            rem_next  = diff[REM_W-1:0];
            root_next = {root_in[DATA_W-2:0], 1'b1};
        end
        else
        begin
            s_next    = s_in << 2;
            rem_next  = rem_sh[REM_W-1:0];
            root_next = {root_in[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= s_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign s    = s_reg;
    assign rem  = rem_reg;
    assign root = root_reg;

endmodule

// ===== hw/rtl/cpc_post.sv =====
// cpc_post: rounding, phase offset and clamp, saturation and the result register
module cpc_post
    import cpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  cpc_side_t             side,
    input  logic signed [XW-1:0]  x,
    input  logic signed [XW-1:0]  y,
    input  logic signed [ZW-1:0]  z,
    input  logic [REM_W-1:0]      rem,
    input  logic [DATA_W-1:0]     root,
    output cpc_rsp_t              rsp
);

    localparam logic signed [XW-1:0] RND   = XW'(longint'(1) <<< (GUARD - 1));
    localparam logic signed [ZW:0]   PI_E  = (ZW+1)'(PI_D);
    localparam logic signed [R_W-1:0] HI_R = R_W'(SAT_HI);
    localparam logic signed [R_W-1:0] LO_R = R_W'(SAT_LO);

    cpc_rsp_t               rsp_next, rsp_reg;
    logic signed [XW-1:0]   rx, ry;
    logic signed [R_W-1:0]  nx, ny;
    logic signed [DATA_W-1:0] part_re, part_im;
    logic                   sat_re, sat_im;
    logic signed [ZW:0]     off, ph_sum;
    logic signed [DATA_W-1:0] ph;
    logic [DATA_W-1:0]      mag;
    logic                   round_up;

    always_comb
    begin
        // rectangular parts
        rx = (x + RND) >>> GUARD;
        ry = (y + RND) >>> GUARD;
        nx = R_W'(rx);
        ny = R_W'(ry);
        if (side.flip)
        begin
            nx = -nx;
            ny = -ny;
        end
        sat_re  = 1'b0;
        sat_im  = 1'b0;
        part_re = DATA_W'(nx);
        part_im = DATA_W'(ny);
        if (nx > HI_R)
        begin
            part_re = SAT_HI;
            sat_re  = 1'b1;
        end
        else if (nx < LO_R)
        begin
            part_re = SAT_LO;
            sat_re  = 1'b1;
        end
        if (ny > HI_R)
        begin
            part_im = SAT_HI;
            sat_im  = 1'b1;
        end
        else if (ny < LO_R)
        begin
            part_im = SAT_LO;
            sat_im  = 1'b1;
        end

        // polar parts
        round_up = (rem > {2'b00, root});
        mag      = root + {{(DATA_W-1){1'b0}}, round_up};
        if (side.re_neg)
        begin
            off = side.im_pos ? PI_E : -PI_E;
        end
        else
        begin
            off = '0;
        end
        ph_sum = (ZW+1)'(z) + off;
        if (side.re_zero)
        begin
            ph = side.im_pos ? HALF_PI_D : -HALF_PI_D;
        end
        else if (ph_sum > PI_E)
        begin
            ph = PI_D;
        end
        else if (ph_sum < -PI_E)
        begin
            ph = -PI_D;
        end
        else
        begin
            ph = DATA_W'(ph_sum);
        end

        if (side.to_rect)
        begin
            rsp_next.out_magnitude = '0;
            rsp_next.out_phase     = '0;
            rsp_next.out_real      = part_re;
            rsp_next.out_imag      = part_im;
            rsp_next.saturated     = sat_re | sat_im;
        end
        else
        begin
            rsp_next.out_magnitude = mag;
            rsp_next.out_phase     = ph;
            rsp_next.out_real      = '0;
            rsp_next.out_imag      = '0;
            rsp_next.saturated     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== hw/rtl/cartesian_polar_converter.sv =====
// cartesian_polar_converter: pipelined cordic rectangular and polar conversion of spectral bins
//
// request channel req_valid/req_ready/req carries one bin per transaction; req_type 0
// turns in_real/in_imag into out_magnitude/out_phase, req_type 1 turns in_magnitude/in_phase
// into out_real/out_imag with saturation flagged; response channel rsp_valid/rsp_ready/rsp
// returns one result per request, in order
// phase is fixed point with pi = 2^22; magnitude is the exactly rounded square root
// a request passes the input stages of cpc_prep, then the cordic and root digit stages
// side by side, NS = max(CORDIC_STAGES, 24) of each, the longer of the two chains,
// then the result register of cpc_post; one cordic stage and one root digit per stage
// throughput: one transaction per cycle unless a stalled receiver has filled every stage
// reset clears only the valid bits, so the pipeline comes up empty
// a stalled receiver holds the result register; earlier stages keep moving until they
// close up behind it, and req_ready drops only when every stage is occupied
module cartesian_polar_converter
    import cpc_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  cpc_req_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output cpc_rsp_t  rsp
);

    localparam int NS = (CORDIC_STAGES > DATA_W) ? CORDIC_STAGES : DATA_W;
    localparam int T  = NS + 3;

    logic [T-1:0] valid_next, valid_reg;
    logic [T-1:0] stage_en;

    cpc_side_t             side_p [0:NS];
    logic signed [XW-1:0]  x_p    [0:NS];
    logic signed [XW-1:0]  y_p    [0:NS];
    logic signed [ZW-1:0]  z_p    [0:NS];
    logic [SQ_W-1:0]       s_p    [0:NS];
    logic [REM_W-1:0]      rem_p  [0:NS];
    logic [DATA_W-1:0]     root_p [0:NS];

    // a stage may load when the output drains or when it or some stage ahead of it is empty
    for (genvar j = 0; j < T; j++)
    begin : g_en
        assign stage_en[j] = rsp_ready | ~(&valid_reg[T-1:j]);
    end

    always_comb
    begin
        valid_next[0] = stage_en[0] ? req_valid : valid_reg[0];
        for (int j = 1; j < T; j++)
        begin
            valid_next[j] = stage_en[j] ? valid_reg[j-1] : valid_reg[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    cpc_prep u_prep (
        .clk  (clk),
        .en_a (stage_en[0]),
        .en_b (stage_en[1]),
        .req  (req),
        .side (side_p[0]),
        .x    (x_p[0]),
        .y    (y_p[0]),
        .z    (z_p[0]),
        .sq   (s_p[0])
    );

    assign rem_p[0]  = '0;
    assign root_p[0] = '0;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        cpc_cordic_stage #(
            .IDX    (k),
            .STAGES (CORDIC_STAGES)
        ) u_cordic (
            .clk     (clk),
            .en      (stage_en[k+2]),
            .side_in (side_p[k]),
            .x_in    (x_p[k]),
            .y_in    (y_p[k]),
            .z_in    (z_p[k]),
            .side    (side_p[k+1]),
            .x       (x_p[k+1]),
            .y       (y_p[k+1]),
            .z       (z_p[k+1])
        );

        cpc_sqrt_stage #(
            .IDX (k)
        ) u_sqrt (
            .clk     (clk),
            .en      (stage_en[k+2]),
            .s_in    (s_p[k]),
            .rem_in  (rem_p[k]),
            .root_in (root_p[k]),
            .s       (s_p[k+1]),
            .rem     (rem_p[k+1]),
            .root    (root_p[k+1])
        );
    end

    cpc_post u_post (
        .clk  (clk),
        .en   (stage_en[T-1]),
        .side (side_p[NS]),
        .x    (x_p[NS]),
        .y    (y_p[NS]),
        .z    (z_p[NS]),
        .rem  (rem_p[NS]),
        .root (root_p[NS]),
        .rsp  (rsp)
    );

    assign req_ready = stage_en[0];
    assign rsp_valid = valid_reg[T-1];

endmodule

// ===== hw/rtl/cpc_checker.sv =====
// cpc_checker: port-level assertions for the converter and the bind that attaches them
module cpc_checker
    import cpc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input cpc_req_t req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input cpc_rsp_t rsp
);

    a_rsp_hold : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_ready_free : assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid || rsp_ready |-> req_ready)
        else $error("request refused with a free output stage");

    a_mode_fields : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.out_magnitude == '0 && rsp.out_phase == '0) ||
                      (rsp.out_real == '0 && rsp.out_imag == '0 && !rsp.saturated))
        else $error("polar and rectangular fields both populated");

    a_phase_range : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.out_phase >= -PI_D && rsp.out_phase <= PI_D)
        else $error("phase outside -pi to pi");

    a_sat_limit : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.saturated |-> rsp.out_real == SAT_HI || rsp.out_real == SAT_LO ||
                                       rsp.out_imag == SAT_HI || rsp.out_imag == SAT_LO)
        else $error("saturation flagged with no part at a limit");

endmodule

bind cartesian_polar_converter cpc_checker u_cpc_checker (.*);

// ===== tb/cartesian_polar_converter_tb.sv =====
// cartesian_polar_converter_tb: checks the cordic converter against a bit-true predictor
`timescale 1ns / 100ps

module cartesian_polar_converter_tb
    import cpc_pkg::*;
();

    localparam int NSTAGES = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;
    localparam int CHUNK_ITEMS = 150;
    localparam int CHUNKS = 12;

    localparam logic REQ_TO_POLAR = 1'b0;
    localparam logic REQ_TO_RECT  = 1'b1;

    localparam longint PHASE_PI   = 64'sd4194304;
    localparam longint PHASE_HALF = 64'sd2097152;
    localparam longint PART_HI    = 64'sd8388607;
    localparam longint PART_LO    = -64'sd8388608;
    localparam longint MAG_MAX    = 64'sd11863283;
    localparam longint unsigned GAIN_INV_Q30 = 64'd652032874;
    localparam int FRAC_BITS = 8;

    // arctangent of 2^-i, pi = 2^22
    localparam longint ARCTAN_STEP [32] = '{
        1048576, 619011, 327068, 166025, 83335, 41708, 20859, 10430,
        5215, 2608, 1304, 652, 326, 163, 81, 41,
        20, 10, 5, 3, 1, 1, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef enum int
    {
        TRAFFIC_FLOW,
        TRAFFIC_SENDER_IDLE,
        TRAFFIC_RECEIVER_STALL,
        TRAFFIC_BOTH
    } traffic_t;

    class cpc_scoreboard;
        cpc_rsp_t expected_q[$];
        int unsigned error_count;
        int unsigned checked_count;

        function cpc_rsp_t convert_bin(cpc_req_t r);
            cpc_rsp_t res;
            longint re, im, x, y, z, off, xs, ys, ph, p;
            longint part [2];
            longint unsigned sq, rem, root, probe, mag;
            bit flip, sat;
            int i, k;
            res = '0;
            if (r.req_type == REQ_TO_POLAR)
            begin
                re = longint'(r.in_real);
                im = longint'(r.in_imag);
                sq = longint'(re * re + im * im);
                rem = sq;
                root = 0;
                probe = 64'd1 << 62;
                while (probe > rem)
                    probe = probe >> 2;
                while (probe != 0)
                begin
                    if (rem >= root + probe)
                    begin
                        rem = rem - (root + probe);
                        root = (root >> 1) + probe;
                    end
                    else
                    begin
                        root = root >> 1;
                    end
                    probe = probe >> 2;
                end
                if (rem > root)
                    root = root + 1;
                if (re == 0)
                begin
                    ph = (im > 0) ? PHASE_HALF : -PHASE_HALF;
                end
                else
                begin
                    x = re * 256;
                    y = im * 256;
                    z = 0;
                    off = 0;
                    if (re < 0)
                    begin
                        x = -x;
                        y = -y;
                        off = (im > 0) ? PHASE_PI : -PHASE_PI;
                    end
                    for (i = 0; i < NSTAGES; i++)
                    begin
                        xs = x >>> i;
                        ys = y >>> i;
                        if (y < 0)
                        begin
                            x = x - ys;
                            y = y + xs;
                            z = z - ARCTAN_STEP[i & 31];
                        end
                        else
                        begin
                            x = x + ys;
                            y = y - xs;
                            z = z + ARCTAN_STEP[i & 31];
                        end
                    end
                    ph = z + off;
                    if (ph > PHASE_PI)
                        ph = PHASE_PI;
                    if (ph < -PHASE_PI)
                        ph = -PHASE_PI;
                end
                res.out_magnitude = root[DATA_W-1:0];
                res.out_phase = ph[DATA_W-1:0];
            end
            else
            begin
                mag = longint'(r.in_magnitude);
                p = longint'($signed(r.in_phase[DATA_W-2:0]));
                flip = 1'b0;
                sat = 1'b0;
                if (p > PHASE_HALF)
                begin
                    p = p - PHASE_PI;
                    flip = 1'b1;
                end
                else if (p < -PHASE_HALF)
                begin
                    p = p + PHASE_PI;
                    flip = 1'b1;
                end
                x = longint'((mag * GAIN_INV_Q30) >> (30 - FRAC_BITS));
                y = 0;
                z = p;
                for (i = 0; i < NSTAGES; i++)
                begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (z >= 0)
                    begin
                        x = x - ys;
                        y = y + xs;
                        z = z - ARCTAN_STEP[i & 31];
                    end
                    else
                    begin
                        x = x + ys;
                        y = y - xs;
                        z = z + ARCTAN_STEP[i & 31];
                    end
                end
                part[0] = (x + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
                part[1] = (y + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
                for (k = 0; k < 2; k++)
                begin
                    if (flip)
                        part[k] = -part[k];
                    if (part[k] > PART_HI)
                    begin
                        part[k] = PART_HI;
                        sat = 1'b1;
                    end
                    if (part[k] < PART_LO)
                    begin
                        part[k] = PART_LO;
                        sat = 1'b1;
                    end
                end
                res.out_real = part[0][DATA_W-1:0];
                res.out_imag = part[1][DATA_W-1:0];
                res.saturated = sat;
            end
            return res;
        endfunction

        function void note_request(cpc_req_t r);
            expected_q.push_back(convert_bin(r));
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("transaction %0d: %s expected %0d got %0d",
                             checked_count, field, want, got);
            end
        endfunction

        function void check_result(cpc_rsp_t got);
            cpc_rsp_t want;
            if (expected_q.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result with no request outstanding");
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_magnitude", longint'(want.out_magnitude),
                          longint'(got.out_magnitude));
            compare_field("out_phase", longint'(want.out_phase), longint'(got.out_phase));
            compare_field("out_real", longint'(want.out_real), longint'(got.out_real));
            compare_field("out_imag", longint'(want.out_imag), longint'(got.out_imag));
            compare_field("saturated", longint'(want.saturated), longint'(got.saturated));
            checked_count++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    cpc_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    cpc_rsp_t rsp;

    int unsigned   send_idle_pct = 0;
    int unsigned   rsp_stall_pct = 0;
    int unsigned   idle_cycles = 0;
    cpc_scoreboard board;

    cartesian_polar_converter #(
        .CORDIC_STAGES(NSTAGES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                board.note_request(req);
            if (rsp_valid && rsp_ready)
                board.check_result(rsp);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic set_traffic(input traffic_t mode);
        case (mode)
            TRAFFIC_SENDER_IDLE:
            begin
                send_idle_pct = 65;
                rsp_stall_pct = 0;
            end
            TRAFFIC_RECEIVER_STALL:
            begin
                send_idle_pct = 0;
                rsp_stall_pct = 65;
            end
            TRAFFIC_BOTH:
            begin
                send_idle_pct = 26;
                rsp_stall_pct = 26;
            end
            default:
            begin
                send_idle_pct = 0;
                rsp_stall_pct = 0;
            end
        endcase
    endtask

    task automatic send_bin(input cpc_req_t item);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    function automatic cpc_req_t make_bin(input logic kind, input longint a, input longint b);
        cpc_req_t item;
        item = '0;
        item.req_type = kind;
        if (kind == REQ_TO_POLAR)
        begin
            item.in_real = a[DATA_W-1:0];
            item.in_imag = b[DATA_W-1:0];
        end
        else
        begin
            item.in_magnitude = a[DATA_W-1:0];
            item.in_phase = b[DATA_W-1:0];
        end
        return item;
    endfunction

    function automatic logic [DATA_W-1:0] extreme_value();
        case ($urandom_range(4))
            0: return PART_HI[DATA_W-1:0];
            1: return PART_LO[DATA_W-1:0];
            2: return DATA_W'(1);
            3: return '1;
            default: return '0;
        endcase
    endfunction

    function automatic cpc_req_t random_bin();
        cpc_req_t item;
        longint centre;
        item.req_type = 1'($urandom_range(1));
        item.in_real = DATA_W'($urandom);
        item.in_imag = DATA_W'($urandom);
        item.in_magnitude = DATA_W'($urandom);
        item.in_phase = DATA_W'($urandom);
        if (item.req_type == REQ_TO_POLAR)
        begin
            case ($urandom_range(9))
                0: item.in_real = '0;
                1: item.in_imag = '0;
                2, 3:
                begin
                    item.in_real = DATA_W'(int'($urandom_range(64)) - 32);
                    item.in_imag = DATA_W'(int'($urandom_range(64)) - 32);
                end
                4:
                begin
                    item.in_real = extreme_value();
                    item.in_imag = extreme_value();
                end
                default: ;
            endcase
        end
        else
        begin
            item.in_magnitude = DATA_W'($urandom_range(0, 32'(MAG_MAX)));
            item.in_phase = DATA_W'(longint'($urandom_range(0, 32'(2 * PHASE_PI))) - PHASE_PI);
            case ($urandom_range(9))
                0: item.in_magnitude = DATA_W'($urandom);
                1: item.in_phase = DATA_W'($urandom);
                2:
                begin
                    centre = PHASE_HALF * (longint'($urandom_range(4)) - 2);
                    item.in_phase = DATA_W'(centre + longint'($urandom_range(8)) - 4);
                end
                3: item.in_magnitude = DATA_W'($urandom_range(300));
                4: item.in_magnitude = DATA_W'($urandom_range(32'(MAG_MAX - 1000), 32'hFFFFFF));
                default: ;
            endcase
        end
        return item;
    endfunction

    initial
    begin
        int chunk;
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_traffic(TRAFFIC_FLOW);
        // zero parts, axis and quadrant rules, extremes of the pair
        send_bin(make_bin(REQ_TO_POLAR, 0, 0));
        send_bin(make_bin(REQ_TO_POLAR, 0, 5));
        send_bin(make_bin(REQ_TO_POLAR, 0, -5));
        send_bin(make_bin(REQ_TO_POLAR, -7, 0));
        send_bin(make_bin(REQ_TO_POLAR, 7, 0));
        send_bin(make_bin(REQ_TO_POLAR, PART_HI, 0));
        send_bin(make_bin(REQ_TO_POLAR, PART_LO, 0));
        send_bin(make_bin(REQ_TO_POLAR, 0, PART_LO));
        send_bin(make_bin(REQ_TO_POLAR, PART_HI, PART_HI));
        send_bin(make_bin(REQ_TO_POLAR, PART_LO, PART_LO));
        send_bin(make_bin(REQ_TO_POLAR, PART_LO, PART_HI));
        send_bin(make_bin(REQ_TO_POLAR, PART_HI, PART_LO));
        send_bin(make_bin(REQ_TO_POLAR, -3, 4));
        send_bin(make_bin(REQ_TO_POLAR, -3, -4));
        send_bin(make_bin(REQ_TO_POLAR, 1, -1));
        // saturation, phase wrap at +pi and quadrant folding
        send_bin(make_bin(REQ_TO_RECT, 0, 0));
        send_bin(make_bin(REQ_TO_RECT, MAG_MAX, 0));
        send_bin(make_bin(REQ_TO_RECT, MAG_MAX, PHASE_HALF / 2));
        send_bin(make_bin(REQ_TO_RECT, MAG_MAX, PHASE_PI));
        send_bin(make_bin(REQ_TO_RECT, 1000000, -PHASE_PI));
        send_bin(make_bin(REQ_TO_RECT, 1000000, PHASE_HALF));
        send_bin(make_bin(REQ_TO_RECT, 1000000, -PHASE_HALF));
        send_bin(make_bin(REQ_TO_RECT, 1000000, PHASE_HALF + 1));
        send_bin(make_bin(REQ_TO_RECT, 24'hFFFFFF, -PHASE_HALF - 1));
        send_bin(make_bin(REQ_TO_RECT, 5000, 24'h7FFFFF));

        for (chunk = 0; chunk < CHUNKS; chunk++)
        begin
            set_traffic(traffic_t'(chunk % 4));
            repeat (CHUNK_ITEMS) send_bin(random_bin());
        end
        req_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.error_count == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
